// ===== src/ple_pkg.sv =====
// Package for the positional list engine: operation and status codes,
// fixed field widths and the command struct broadcast to the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_REM_FIRST = 3'd3,
    OP_REM_LAST  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_GET       = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // ins: open a gap at the position and load the element there
  // rem: close the gap at the position by pulling from the right
  typedef struct packed {
    logic ins;
    logic rem;
  } ple_cmd_t;

endpackage : ple_pkg

`default_nettype wire

// ===== src/ple_cell.sv =====
// One storage cell of the list row: holds, loads the new element, or
// takes its left or right neighbour's value. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
  parameter int unsigned ELEMENT_BITS = 32,
  parameter int unsigned IDX_W        = 4,
  parameter int unsigned INDEX        = 0
) (
  input  wire                    clk_i,
  input  wire ple_pkg::ple_cmd_t cmd_i,
  input  wire [IDX_W-1:0]        at_i,
  input  wire [ELEMENT_BITS-1:0] element_i,
  input  wire [ELEMENT_BITS-1:0] left_i,
  input  wire [ELEMENT_BITS-1:0] right_i,
  output logic [ELEMENT_BITS-1:0] data_o
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ELEMENT_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins) begin
      if (MyIdx == at_i) begin
        data_d = element_i;
      end else if (MyIdx > at_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (MyIdx >= at_i) begin
        data_d = right_i;
      end
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : ple_cell

`default_nettype wire

// ===== src/positional_list_engine_unit.sv =====
// Top level of the positional list engine: request decode, element count,
// cell row and registered result. Depends on ple_pkg and ple_cell.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed elements, front in cell 0. On
// acceptance a command and a gap position are broadcast to a row of
// cells, each of which holds, loads the element or takes a neighbour's
// value in that same edge, while status, read value, size and empty flag
// are captured in the output register. A request is accepted whenever
// the output register is empty or being taken, so one item per cycle is
// sustained while out_ready_i is high. Reads reach the first CAPACITY
// positions, at most 16 (POS_W). Only count and valid have a reset.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY     = 16,
  parameter int unsigned ELEMENT_BITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire [ple_pkg::OP_W-1:0]             operation_i,
  input  wire [ple_pkg::POS_W-1:0]            position_i,
  input  wire signed [ELEMENT_BITS-1:0]       element_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [ple_pkg::STATUS_W-1:0]        status_o,
  output logic signed [ELEMENT_BITS-1:0]      value_o,
  output logic [ple_pkg::SIZE_W-1:0]          fill_count_o,
  output logic                                is_empty_o
);
  import ple_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
  localparam int unsigned RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q;
  logic [ELEMENT_BITS-1:0] value_q;
  logic [SIZE_W-1:0]       size_q;
  logic                    empty_q;

  logic                    accept;
  logic                    full;
  logic                    pos_hit;
  logic [CMP_W-1:0]        pos_ext, cnt_ext;
  status_e                 status_d;
  logic [ELEMENT_BITS-1:0] value_d;
  logic [ELEMENT_BITS-1:0] rd_data;
  logic                    ins_d, rem_d;
  logic [IDX_W-1:0]        at_d;
  ple_cmd_t                cmd;

  logic [ELEMENT_BITS-1:0] cell_q [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign pos_hit = (pos_ext < cnt_ext);

  always_comb begin
    rd_data = '1;
    for (int j = 0; j < RD_N; j++) begin
      if (position_i == POS_W'(j)) begin
        rd_data = cell_q[j];
      end
    end
  end

  always_comb begin
    status_d = ST_NONE;
    value_d  = '1;
    count_d  = count_q;
    ins_d    = 1'b0;
    rem_d    = 1'b0;
    at_d     = '0;
    unique case (operation_i)
      OP_INS_FIRST: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          ins_d    = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      OP_INS_LAST: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          ins_d    = 1'b1;
          at_d     = IDX_W'(count_q);
          count_d  = count_q + 1'b1;
        end
      end
      OP_INS_AFTER: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_hit) begin
          status_d = ST_DONE;
          ins_d    = 1'b1;
          at_d     = IDX_W'(pos_ext + 1'b1);
          count_d  = count_q + 1'b1;
        end
      end
      OP_REM_FIRST: begin
        if (count_q != '0) begin
          status_d = ST_DONE;
          rem_d    = 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      OP_REM_LAST: begin
        if (count_q != '0) begin
          status_d = ST_DONE;
          count_d  = count_q - 1'b1;
        end
      end
      OP_REM_AT: begin
        if (pos_hit) begin
          status_d = ST_DONE;
          rem_d    = 1'b1;
          at_d     = IDX_W'(position_i);
          count_d  = count_q - 1'b1;
        end
      end
      OP_GET: begin
        if (pos_hit) begin
          status_d = ST_DONE;
          value_d  = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.ins = accept && ins_d;
  assign cmd.rem = accept && rem_d;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_q[i+1];
    end
    ple_cell #(
      .ELEMENT_BITS(ELEMENT_BITS),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .at_i     (at_d),
      .element_i(element_i),
      .left_i   (left),
      .right_i  (right),
      .data_o   (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      size_q   <= SIZE_W'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_o      = value_q;
  assign fill_count_o = size_q;
  assign is_empty_o   = empty_q;

endmodule : positional_list_engine_unit

`default_nettype wire
